// File: rtl/swe_pkg.sv
// ---------------------------------------------------------------------------
// Soundex word encoder package
// Types, constants and the letter class mapping shared by the encoder files.
// ---------------------------------------------------------------------------
package swe_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] digit_t;
	typedef logic [1:0] count_t;

	// Class codes; a skipped letter never produces a digit.
	localparam digit_t CLASS_SKIP  = 3'd0;
	localparam digit_t CLASS_LABIAL = 3'd1;
	localparam digit_t CLASS_SIBIL = 3'd2;
	localparam digit_t CLASS_DENTAL = 3'd3;
	localparam digit_t CLASS_NASAL = 3'd4;
	localparam digit_t CLASS_LIQUID = 3'd5;
	localparam digit_t CLASS_OTHER = 3'd6;

	// Number of digits kept in a code.
	localparam count_t NUM_DIGITS = 2'd3;

	localparam byte_t CASE_OFFSET = 8'd32;

	// Folds ASCII lower case to upper case and returns the byte's class.
	function automatic digit_t class_of(input byte_t ch);
		byte_t  u;
		digit_t cls;
		u = ch;
		if (ch >= byte_t'("a") && ch <= byte_t'("z")) begin
			u = ch - CASE_OFFSET;
		end
		unique case (u)
			"A", "E", "I", "O", "U", "H", "W", "Y": cls = CLASS_SKIP;
			"B", "F", "P", "V":                     cls = CLASS_LABIAL;
			"C", "G", "J", "K", "Q", "S", "X", "Z": cls = CLASS_SIBIL;
			"D", "T":                               cls = CLASS_DENTAL;
			"M", "N":                               cls = CLASS_NASAL;
			"L":                                    cls = CLASS_LIQUID;
			default:                                cls = CLASS_OTHER;
		endcase
		return cls;
	endfunction

endpackage

// File: rtl/swe_char_if.sv
// ---------------------------------------------------------------------------
// Soundex character channel
// Valid/ready channel carrying one byte of a word and its end-of-word flag.
// ---------------------------------------------------------------------------
interface swe_char_if;

	logic           valid;
	logic           ready;
	swe_pkg::byte_t char_in;
	logic           word_end;

	modport source (output valid, output char_in, output word_end, input ready);
	modport sink   (input valid, input char_in, input word_end, output ready);

endinterface

// File: rtl/swe_code_if.sv
// ---------------------------------------------------------------------------
// Soundex code channel
// Valid/ready channel carrying one finished code: lead byte and three digits.
// ---------------------------------------------------------------------------
interface swe_code_if;

	logic            valid;
	logic            ready;
	swe_pkg::byte_t  lead_letter;
	swe_pkg::digit_t digit_one;
	swe_pkg::digit_t digit_two;
	swe_pkg::digit_t digit_three;

	modport source (output valid, output lead_letter, output digit_one,
		output digit_two, output digit_three, input ready);
	modport sink   (input valid, input lead_letter, input digit_one,
		input digit_two, input digit_three, output ready);

endinterface

// File: rtl/soundex_word_encoder.sv
// ---------------------------------------------------------------------------
// Soundex word encoder
// Builds a lead byte plus three class digits from a stream of word bytes.
// ---------------------------------------------------------------------------
// A word's code is loaded into the code register as its last byte is processed.
// Throughput: one byte per cycle; the input register and the code register
// are decoupled, so bytes keep flowing while a finished code waits, and a
// byte is held back only when the last byte of a word meets a full code register.
// Reset: arst_n clears the word state and both valid flags asynchronously.
// ---------------------------------------------------------------------------
module soundex_word_encoder (
	input  logic       clk,
	input  logic       arst_n,
	swe_char_if.sink   char_chan,
	swe_code_if.source code_chan
);

	// Input register stage.
	logic           valid_s1;
	swe_pkg::byte_t char_s1;
	logic           end_s1;

	// Word state, updated as each registered byte is processed.
	logic             in_word_q;
	swe_pkg::byte_t   lead_q;
	swe_pkg::digit_t  digits_q [3];
	swe_pkg::count_t  count_q;
	swe_pkg::digit_t  prev_q;

	// Result register.
	logic             out_valid_q;
	swe_pkg::byte_t   out_lead_q;
	swe_pkg::digit_t  out_digits_q [3];

	logic             advance;
	logic             process;
	logic             in_fire;
	swe_pkg::digit_t  cls;
	logic             take;
	swe_pkg::byte_t   lead_n;
	swe_pkg::digit_t  digits_n [3];
	swe_pkg::count_t  count_n;
	swe_pkg::digit_t  prev_n;

	// The registered byte may move on unless it closes a word and the code
	// register still holds a code nobody has taken.
	assign advance = !end_s1 || !out_valid_q || code_chan.ready;
	assign process = valid_s1 && advance;
	assign char_chan.ready = !valid_s1 || advance;
	assign in_fire = char_chan.valid && char_chan.ready;

	// Class of the registered byte; the first byte of a word is only held,
	// so its class never counts.
	assign cls  = swe_pkg::class_of(char_s1);
	assign take = in_word_q && (cls != swe_pkg::CLASS_SKIP) && (cls != prev_q);

	always_comb begin
		lead_n   = in_word_q ? lead_q : char_s1;
		digits_n = digits_q;
		count_n  = count_q;
		prev_n   = prev_q;
		if (take) begin
			// The class is remembered even once three digits are held, so a
			// run that continues past the third digit stays collapsed.
			prev_n = cls;
			if (count_q < swe_pkg::NUM_DIGITS) begin
				digits_n[count_q] = cls;
				count_n           = count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1 <= char_chan.char_in;
			end_s1  <= char_chan.word_end;
		end
	end

	// Word state: a word's last byte returns everything to the reset values
	// so that the next byte starts a fresh word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			lead_q    <= '0;
			digits_q  <= '{default: swe_pkg::CLASS_SKIP};
			count_q   <= '0;
			prev_q    <= swe_pkg::CLASS_SKIP;
		end else if (process) begin
			if (end_s1) begin
				in_word_q <= 1'b0;
				lead_q    <= '0;
				digits_q  <= '{default: swe_pkg::CLASS_SKIP};
				count_q   <= '0;
				prev_q    <= swe_pkg::CLASS_SKIP;
			end else begin
				in_word_q <= 1'b1;
				lead_q    <= lead_n;
				digits_q  <= digits_n;
				count_q   <= count_n;
				prev_q    <= prev_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !code_chan.ready) || (process && end_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (process && end_s1) begin
			out_lead_q   <= lead_n;
			out_digits_q <= digits_n;
		end
	end

	assign code_chan.valid       = out_valid_q;
	assign code_chan.lead_letter = out_lead_q;
	assign code_chan.digit_one   = out_digits_q[0];
	assign code_chan.digit_two   = out_digits_q[1];
	assign code_chan.digit_three = out_digits_q[2];

endmodule

// File: verif/soundex_word_encoder_checker.sv
// ---------------------------------------------------------------------------
// Soundex word encoder checker
// Watches both channels, predicts the code of each finished word and compares
// every code request that leaves the encoder with the oldest prediction.
// ---------------------------------------------------------------------------
module soundex_word_encoder_checker (
	input  logic clk,
	input  logic arst_n,
	swe_char_if  char_chan,
	swe_code_if  code_chan,
	output int   mismatch_count,
	output int   codes_pending
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		swe_pkg::byte_t  lead;
		swe_pkg::digit_t first;
		swe_pkg::digit_t second;
		swe_pkg::digit_t third;
	} soundex_code_t;

	soundex_code_t expected_codes[$];

	// Running state of the word being assembled.
	logic            word_open;
	swe_pkg::byte_t  lead_held;
	swe_pkg::digit_t digits_held [swe_pkg::NUM_DIGITS];
	swe_pkg::count_t digits_kept;
	swe_pkg::digit_t last_digit;
	int              fault_count;

	function automatic swe_pkg::digit_t byte_class(input swe_pkg::byte_t ch);
		swe_pkg::byte_t up;
		up = ch;
		if (ch >= "a" && ch <= "z") begin
			up = ch & 8'hDF;
		end
		case (up)
			"A", "E", "I", "O", "U", "H", "W", "Y": return swe_pkg::CLASS_SKIP;
			"B", "F", "P", "V":                     return swe_pkg::CLASS_LABIAL;
			"C", "G", "J", "K", "Q", "S", "X", "Z": return swe_pkg::CLASS_SIBIL;
			"D", "T":                               return swe_pkg::CLASS_DENTAL;
			"M", "N":                               return swe_pkg::CLASS_NASAL;
			"L":                                    return swe_pkg::CLASS_LIQUID;
			default:                                return swe_pkg::CLASS_OTHER;
		endcase
	endfunction

	function automatic void clear_word();
		word_open   = 1'b0;
		lead_held   = '0;
		digits_kept = '0;
		last_digit  = swe_pkg::CLASS_SKIP;
		foreach (digits_held[i]) digits_held[i] = swe_pkg::CLASS_SKIP;
	endfunction

	// Folds one accepted byte into the word and queues a code on the word's end.
	function automatic void absorb_byte(input swe_pkg::byte_t ch, input logic word_end);
		swe_pkg::digit_t cls;
		soundex_code_t   finished;
		if (!word_open) begin
			lead_held = ch;
			word_open = 1'b1;
		end else begin
			cls = byte_class(ch);
			if (cls != swe_pkg::CLASS_SKIP && cls != last_digit) begin
				if (digits_kept < swe_pkg::NUM_DIGITS) begin
					digits_held[digits_kept] = cls;
					digits_kept++;
				end
				last_digit = cls;
			end
		end
		if (word_end) begin
			finished = '{lead_held, digits_held[0], digits_held[1], digits_held[2]};
			expected_codes.insert(expected_codes.size(), finished);
			clear_word();
		end
	endfunction

	function automatic void check_code(input soundex_code_t got);
		soundex_code_t want;
		if (expected_codes.size() == 0) begin
			fault_count++;
			if (fault_count <= MAX_REPORTS) begin
				$display("unexpected code: lead %h digits %0d %0d %0d", got.lead,
					got.first, got.second, got.third);
			end
		end else begin
			want = expected_codes.pop_front();
			if (got != want) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS) begin
					$display("code mismatch: expected %h %0d %0d %0d, got %h %0d %0d %0d",
						want.lead, want.first, want.second, want.third,
						got.lead, got.first, got.second, got.third);
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_word();
			expected_codes.delete();
			fault_count = 0;
			mismatch_count <= 0;
			codes_pending  <= 0;
		end else begin
			// A code leaving now belongs to an earlier word, so it is checked
			// before the byte taken at this edge is folded in.
			if (code_chan.valid && code_chan.ready) begin
				check_code('{code_chan.lead_letter, code_chan.digit_one,
					code_chan.digit_two, code_chan.digit_three});
			end
			if (char_chan.valid && char_chan.ready) begin
				absorb_byte(char_chan.char_in, char_chan.word_end);
			end
			mismatch_count <= fault_count;
			codes_pending  <= expected_codes.size();
		end
	end

endmodule

// File: verif/soundex_word_encoder_tb.sv
// ---------------------------------------------------------------------------
// Soundex word encoder testbench
// Sends directed and random words to the encoder in bursts, stalls the code
// channel on its own pattern and lets the checker judge every code.
// ---------------------------------------------------------------------------
module soundex_word_encoder_tb;

	// Upper bound on the run in clock cycles.
	localparam int CYCLE_LIMIT   = 100000;
	// Roughly how many random bytes follow the directed words.
	localparam int RANDOM_BYTES  = 850;
	// Cycles allowed after the last expected code.
	localparam int DRAIN_CYCLES  = 8;

	typedef struct packed {
		swe_pkg::byte_t ch;
		logic           word_end;
	} word_byte_t;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   codes_pending;
	int   cycle_count;

	// Every byte to be sent, in order; built up front and then drained.
	word_byte_t byte_stream[$];

	swe_char_if char_chan ();
	swe_code_if code_chan ();

	soundex_word_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_chan (char_chan),
		.code_chan (code_chan)
	);

	soundex_word_encoder_checker checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_chan      (char_chan),
		.code_chan      (code_chan),
		.mismatch_count (mismatch_count),
		.codes_pending  (codes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here rather than running forever.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	function automatic void queue_byte(input swe_pkg::byte_t ch, input logic word_end);
		word_byte_t entry;
		entry = '{ch, word_end};
		byte_stream.insert(byte_stream.size(), entry);
	endfunction

	function automatic void queue_word(input string text);
		for (int i = 0; i < text.len(); i++) begin
			queue_byte(text[i], i == text.len() - 1);
		end
	endfunction

	// A random word is mostly letters of either case, so that real codes build
	// up, with doubled letters to exercise runs and the odd arbitrary byte.
	function automatic void queue_random_word();
		int             length;
		int             pick;
		swe_pkg::byte_t ch;
		swe_pkg::byte_t prev;
		length = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
		prev = "A";
		for (int i = 0; i < length; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10 && i > 0) begin
				ch = prev;
			end else if (pick < 82) begin
				ch = 8'("A" + $urandom_range(0, 25));
				if ($urandom_range(0, 1) == 1) begin
					ch = ch | 8'h20;
				end
			end else begin
				ch = 8'($urandom_range(0, 255));
			end
			queue_byte(ch, i == length - 1);
			prev = ch;
		end
	endfunction

	// Receiver: the ready pattern moves between phases of steady readiness,
	// coin-toss stalls and mostly-low readiness, so codes back up behind the register.
	initial begin
		int mode;
		int span;
		code_chan.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(10, 60);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0:       code_chan.ready <= 1'b1;
					1:       code_chan.ready <= 1'($urandom_range(0, 1));
					default: code_chan.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Sender: resets the block, then drains the byte stream in bursts. Inputs
	// change only on the falling edge, and a request is taken as accepted at
	// the first rising edge that sees ready high.
	initial begin
		int burst_left;
		int idle;
		word_byte_t item;
		arst_n            = 1'b0;
		char_chan.valid    = 1'b0;
		char_chan.char_in  = '0;
		char_chan.word_end = 1'b0;

		// Directed words. A single-byte word gives a bare lead with zero padding,
		// whichever byte it is. The next word runs past three digits, so its final
		// consonant is dropped. Then a lower-case lead whose run of one class is
		// split by a skipped letter and must not restart. Then a word with a zero
		// lead, a nasal letter, a byte above the ASCII range and the bytes just
		// outside the lower-case letters, which fall in the catch-all class.
		queue_word("z");
		queue_byte(8'hFF, 1'b1);
		queue_word("Pfister");
		queue_word("aLhl");
		queue_byte(8'h00, 1'b0);
		queue_byte("m", 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h60, 1'b0);
		queue_byte("{", 1'b1);
		queue_word("Yd");

		// Random words, each closed by its end flag so that no byte is left over.
		while (byte_stream.size() < RANDOM_BYTES + 20) begin
			queue_random_word();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		burst_left = $urandom_range(1, 24);
		while (byte_stream.size() > 0) begin
			if (burst_left == 0) begin
				// Gap between bursts; the payload is scrambled while valid is low.
				idle = $urandom_range(1, 6);
				@(negedge clk);
				char_chan.valid    <= 1'b0;
				char_chan.char_in  <= 8'($urandom_range(0, 255));
				char_chan.word_end <= 1'($urandom_range(0, 1));
				repeat (idle - 1) @(negedge clk);
				// Now and then a long burst with no gaps at all.
				burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 24);
			end
			item = byte_stream.pop_front();
			@(negedge clk);
			char_chan.valid    <= 1'b1;
			char_chan.char_in  <= item.ch;
			char_chan.word_end <= item.word_end;
			@(posedge clk);
			while (!char_chan.ready) @(posedge clk);
			burst_left--;
		end
		@(negedge clk);
		char_chan.valid <= 1'b0;

		// Let every outstanding code arrive, then watch a little longer for
		// anything spurious before giving the verdict.
		while (codes_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && codes_pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: soundex_word_encoder.f
rtl/swe_pkg.sv
rtl/swe_char_if.sv
rtl/swe_code_if.sv
rtl/soundex_word_encoder.sv
verif/soundex_word_encoder_checker.sv
verif/soundex_word_encoder_tb.sv
